@@ rtl/bca_pkg.sv @@
package bca_pkg;

    localparam int NUM_BLOCKS       = 256;
    localparam int DIR_ENTRIES      = 16;
    localparam int FIRST_DATA_BLOCK = 4;
    localparam int NAME_CHARS       = 8;

    localparam int BLK_W  = 8;
    localparam int NAME_W = 64;
    localparam int DIR_W  = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(NUM_BLOCKS) + 1;

    localparam logic [NAME_W-1:0] NAME_MASK =
        ~((64'd1 << (NAME_W - 8 * NAME_CHARS)) - 64'd1);

    localparam logic [BLK_W-1:0] FREE_HEAD_RST =
        (FIRST_DATA_BLOCK < NUM_BLOCKS) ? BLK_W'(FIRST_DATA_BLOCK) : '0;

    typedef enum logic [2:0] {
        REQ_CREATE    = 3'd0,
        REQ_REMOVE    = 3'd1,
        REQ_GET_FIRST = 3'd2,
        REQ_APPEND    = 3'd3,
        REQ_DELETE    = 3'd4,
        REQ_CHECK     = 3'd5,
        REQ_NEXT      = 3'd6,
        REQ_NONE      = 3'd7
    } req_t;

    typedef enum logic [2:0] {
        STAT_OK          = 3'd0,
        STAT_NOT_FOUND   = 3'd1,
        STAT_EXISTS      = 3'd2,
        STAT_DIR_FULL    = 3'd3,
        STAT_NOT_EMPTY   = 3'd4,
        STAT_STORE_FULL  = 3'd5,
        STAT_NOT_IN_FILE = 3'd6,
        STAT_RSVD        = 3'd7
    } status_t;

    typedef struct packed {
        logic             en;
        logic [BLK_W-1:0] addr;
        logic [BLK_W-1:0] data;
    } link_wr_t;

    // Link value of a block that has not been written since reset
    function automatic logic [BLK_W-1:0] link_rst(input logic [BLK_W-1:0] blk);
        logic [CNT_W-1:0] nxt;
        nxt = CNT_W'(blk) + CNT_W'(1);
        if (CNT_W'(blk) < CNT_W'(FIRST_DATA_BLOCK)) begin
            return '0;
        end else if (nxt < CNT_W'(NUM_BLOCKS)) begin
            return nxt[BLK_W-1:0];
        end else begin
            return '0;
        end
    endfunction

endpackage

@@ rtl/bca_ram.sv @@
module bca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/bca_link.sv @@
module bca_link (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  bca_pkg::link_wr_t         wr,
    input  logic [bca_pkg::BLK_W-1:0] rd_addr,
    output logic [bca_pkg::BLK_W-1:0] rd_data
);

    logic [bca_pkg::NUM_BLOCKS-1:0] written_reg;
    logic [bca_pkg::BLK_W-1:0]      addr_reg;
    logic                           hit_reg;
    logic [bca_pkg::BLK_W-1:0]      ram_q;

    bca_ram #(
        .WIDTH(bca_pkg::BLK_W),
        .DEPTH(bca_pkg::NUM_BLOCKS)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (wr.en),
        .wr_addr(wr.addr),
        .wr_data(wr.data),
        .rd_addr(rd_addr),
        .rd_data(ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
        end else if (wr.en) begin
            written_reg[wr.addr] <= 1'b1;
        end
        addr_reg <= rd_addr;
        hit_reg  <= written_reg[rd_addr];
    end

    // unwritten entries read as their reset link
    assign rd_data = hit_reg ? ram_q : bca_pkg::link_rst(addr_reg);

endmodule

@@ rtl/block_chain_allocator.sv @@
// Block chain allocator: a directory of up to 16 named files, each owning a
// chain of blocks in a 256-entry link table, plus an ascending free list.
// Slave channel carries one request: s_tuser is the request kind, s_tdata
// the name and block number. Master channel returns exactly one result per
// request: m_tuser is the status, m_tdata the block number (0 when none).
// Requests are handled one at a time; s_tready is high only while idle.
// The directory scan covers every slot, one slot a cycle through a single
// compare; a chain or the free list is walked one link at a time through
// the link memory (one read port, registered data), and each result then
// sits in the output register.
// Reset (aresetn low, synchronous) empties the directory, sets the free
// head to the first data block and marks every link entry as unwritten, so
// it reads back its reset link at once: no clearing pass is needed.
// When the receiver stalls, the result is held on m_tdata/m_tuser and no
// new request is taken until it has been accepted.
module block_chain_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // file_name [63:0], block_num [71:64]
    input  logic [2:0]  s_tuser,   // req_type [2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // block_out [7:0]
    output logic [2:0]  m_tuser    // status [2:0]
);

    localparam int BW = bca_pkg::BLK_W;
    localparam int DW = bca_pkg::DIR_W;
    localparam int CW = bca_pkg::CNT_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SEARCH, ST_DISPATCH,
        ST_IC_TEST, ST_IC_WAIT, ST_LB_RD, ST_LB_WAIT,
        ST_FI_START, ST_FI_RD, ST_FI_WAIT, ST_FI_W2,
        ST_AP_WAIT, ST_AP_RD, ST_AP_WAIT2, ST_OUT
    } state_t;

    state_t                        state_reg, state_next;
    bca_pkg::req_t                 req_reg, req_next;
    logic [bca_pkg::NAME_W-1:0]    name_reg, name_next;
    logic [BW-1:0]                 b_reg, b_next;
    logic [DW-1:0]                 idx_reg, idx_next;
    logic                          found_reg, found_next;
    logic [DW-1:0]                 slot_reg, slot_next;
    logic                          fok_reg, fok_next;
    logic [DW-1:0]                 fslot_reg, fslot_next;
    logic [BW-1:0]                 cur_reg, cur_next;
    logic [BW-1:0]                 prev_reg, prev_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic [BW-1:0]                 nb_reg, nb_next;
    logic [BW-1:0]                 head_reg, head_next;
    logic [bca_pkg::NAME_W-1:0]    dname_reg [bca_pkg::DIR_ENTRIES];
    logic [bca_pkg::NAME_W-1:0]    dname_next [bca_pkg::DIR_ENTRIES];
    logic [bca_pkg::DIR_ENTRIES-1:0] dvalid_reg, dvalid_next;
    logic [BW-1:0]                 dfirst_reg [bca_pkg::DIR_ENTRIES];
    logic [BW-1:0]                 dfirst_next [bca_pkg::DIR_ENTRIES];
    logic                          mvalid_reg, mvalid_next;
    bca_pkg::status_t              mstat_reg, mstat_next;
    logic [BW-1:0]                 mblk_reg, mblk_next;

    bca_pkg::link_wr_t             lwr;
    logic [BW-1:0]                 lrd_addr;
    logic [BW-1:0]                 lrd_data;
    logic [BW-1:0]                 first_s;

    bca_link u_link (
        .aclk   (aclk),
        .aresetn(aresetn),
        .wr     (lwr),
        .rd_addr(lrd_addr),
        .rd_data(lrd_data)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mblk_reg;
    assign m_tuser  = mstat_reg;
    assign first_s  = dfirst_reg[slot_reg];

    always_comb begin
        state_next  = state_reg;
        req_next    = req_reg;
        name_next   = name_reg;
        b_next      = b_reg;
        idx_next    = idx_reg;
        found_next  = found_reg;
        slot_next   = slot_reg;
        fok_next    = fok_reg;
        fslot_next  = fslot_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        cnt_next    = cnt_reg;
        nb_next     = nb_reg;
        head_next   = head_reg;
        dname_next  = dname_reg;
        dvalid_next = dvalid_reg;
        dfirst_next = dfirst_reg;
        mvalid_next = mvalid_reg;
        mstat_next  = mstat_reg;
        mblk_next   = mblk_reg;
        lwr         = '0;
        lrd_addr    = cur_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    req_next   = bca_pkg::req_t'(s_tuser);
                    name_next  = s_tdata[63:0] & bca_pkg::NAME_MASK;
                    b_next     = s_tdata[71:64];
                    idx_next   = '0;
                    found_next = 1'b0;
                    fok_next   = 1'b0;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                // one slot a cycle through the shared name compare
                if (dvalid_reg[idx_reg] && dname_reg[idx_reg] == name_reg && !found_reg) begin
                    found_next = 1'b1;
                    slot_next  = idx_reg;
                end
                if (!dvalid_reg[idx_reg] && !fok_reg) begin
                    fok_next   = 1'b1;
                    fslot_next = idx_reg;
                end
                idx_next = idx_reg + DW'(1);
                if (idx_reg == DW'(bca_pkg::DIR_ENTRIES - 1)) begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                lrd_addr    = head_reg;
                mvalid_next = 1'b1;
                mstat_next  = bca_pkg::STAT_OK;
                mblk_next   = '0;
                state_next  = ST_OUT;
                cur_next    = first_s;
                prev_next   = '0;
                cnt_next    = '0;
                case (req_reg) inside
                    bca_pkg::REQ_CREATE: begin
                        if (found_reg) begin
                            mstat_next = bca_pkg::STAT_EXISTS;
                        end else if (!fok_reg) begin
                            mstat_next = bca_pkg::STAT_DIR_FULL;
                        end else begin
                            dvalid_next[fslot_reg] = 1'b1;
                            dname_next[fslot_reg]  = name_reg;
                            dfirst_next[fslot_reg] = '0;
                        end
                    end
                    bca_pkg::REQ_REMOVE: begin
                        if (!found_reg) begin
                            mstat_next = bca_pkg::STAT_NOT_FOUND;
                        end else if (first_s != '0) begin
                            mstat_next = bca_pkg::STAT_NOT_EMPTY;
                        end else begin
                            dvalid_next[slot_reg] = 1'b0;
                        end
                    end
                    bca_pkg::REQ_GET_FIRST: begin
                        if (!found_reg) begin
                            mstat_next = bca_pkg::STAT_NOT_FOUND;
                        end else begin
                            mblk_next = first_s;
                        end
                    end
                    bca_pkg::REQ_APPEND: begin
                        if (head_reg == '0) begin
                            mstat_next = bca_pkg::STAT_STORE_FULL;
                        end else if (!found_reg) begin
                            mstat_next = bca_pkg::STAT_NOT_FOUND;
                        end else begin
                            mvalid_next = 1'b0;
                            state_next  = ST_AP_WAIT;
                        end
                    end
                    bca_pkg::REQ_DELETE, bca_pkg::REQ_CHECK, bca_pkg::REQ_NEXT: begin
                        if (!found_reg) begin
                            mstat_next = bca_pkg::STAT_NOT_FOUND;
                        end else begin
                            mvalid_next = 1'b0;
                            state_next  = ST_IC_TEST;
                        end
                    end
                    default: begin
                        // unknown request: plain ok
                    end
                endcase
            end
            ST_IC_TEST: begin
                lrd_addr = cur_reg;
                if (cur_reg == '0 || cnt_reg == CW'(bca_pkg::NUM_BLOCKS)) begin
                    mvalid_next = 1'b1;
                    mstat_next  = bca_pkg::STAT_NOT_IN_FILE;
                    mblk_next   = '0;
                    state_next  = ST_OUT;
                end else if (cur_reg == b_reg) begin
                    state_next = ST_LB_RD;
                end else begin
                    state_next = ST_IC_WAIT;
                end
            end
            ST_IC_WAIT: begin
                prev_next  = cur_reg;
                cur_next   = lrd_data;
                cnt_next   = cnt_reg + CW'(1);
                state_next = ST_IC_TEST;
            end
            ST_LB_RD: begin
                lrd_addr   = b_reg;
                state_next = ST_LB_WAIT;
            end
            ST_LB_WAIT: begin
                if (req_reg == bca_pkg::REQ_DELETE) begin
                    // unlink the block from its chain
                    if (first_s == b_reg) begin
                        dfirst_next[slot_reg] = lrd_data;
                    end else begin
                        lwr.en   = 1'b1;
                        lwr.addr = prev_reg;
                        lwr.data = lrd_data;
                    end
                    state_next = ST_FI_START;
                end else begin
                    mvalid_next = 1'b1;
                    mstat_next  = bca_pkg::STAT_OK;
                    mblk_next   = (req_reg == bca_pkg::REQ_CHECK) ? b_reg : lrd_data;
                    state_next  = ST_OUT;
                end
            end
            ST_FI_START: begin
                if (head_reg == '0 || head_reg > b_reg) begin
                    lwr.en      = 1'b1;
                    lwr.addr    = b_reg;
                    lwr.data    = head_reg;
                    head_next   = b_reg;
                    mvalid_next = 1'b1;
                    mstat_next  = bca_pkg::STAT_OK;
                    mblk_next   = '0;
                    state_next  = ST_OUT;
                end else begin
                    cur_next   = head_reg;
                    cnt_next   = '0;
                    state_next = ST_FI_RD;
                end
            end
            ST_FI_RD: begin
                lrd_addr   = cur_reg;
                state_next = ST_FI_WAIT;
            end
            ST_FI_WAIT: begin
                if (cnt_reg != CW'(bca_pkg::NUM_BLOCKS) && lrd_data != '0
                    && lrd_data < b_reg) begin
                    cur_next   = lrd_data;
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = ST_FI_RD;
                end else begin
                    lwr.en     = 1'b1;
                    lwr.addr   = b_reg;
                    lwr.data   = lrd_data;
                    state_next = ST_FI_W2;
                end
            end
            ST_FI_W2: begin
                lwr.en      = 1'b1;
                lwr.addr    = cur_reg;
                lwr.data    = b_reg;
                mvalid_next = 1'b1;
                mstat_next  = bca_pkg::STAT_OK;
                mblk_next   = '0;
                state_next  = ST_OUT;
            end
            ST_AP_WAIT: begin
                // pop the free head and terminate the new block
                nb_next   = head_reg;
                head_next = lrd_data;
                lwr.en    = 1'b1;
                lwr.addr  = head_reg;
                lwr.data  = '0;
                if (first_s == '0) begin
                    dfirst_next[slot_reg] = head_reg;
                    mvalid_next = 1'b1;
                    mstat_next  = bca_pkg::STAT_OK;
                    mblk_next   = head_reg;
                    state_next  = ST_OUT;
                end else begin
                    cur_next   = first_s;
                    cnt_next   = '0;
                    state_next = ST_AP_RD;
                end
            end
            ST_AP_RD: begin
                lrd_addr   = cur_reg;
                state_next = ST_AP_WAIT2;
            end
            ST_AP_WAIT2: begin
                if (lrd_data != '0 && cnt_reg != CW'(bca_pkg::NUM_BLOCKS)) begin
                    cur_next   = lrd_data;
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = ST_AP_RD;
                end else begin
                    lwr.en      = 1'b1;
                    lwr.addr    = cur_reg;
                    lwr.data    = nb_reg;
                    mvalid_next = 1'b1;
                    mstat_next  = bca_pkg::STAT_OK;
                    mblk_next   = nb_reg;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    mvalid_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            head_reg   <= bca_pkg::FREE_HEAD_RST;
            dvalid_reg <= '0;
            mvalid_reg <= 1'b0;
            for (int i = 0; i < bca_pkg::DIR_ENTRIES; i++) begin
                dfirst_reg[i] <= '0;
            end
        end else begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            dvalid_reg <= dvalid_next;
            mvalid_reg <= mvalid_next;
            dfirst_reg <= dfirst_next;
        end
        req_reg   <= req_next;
        name_reg  <= name_next;
        b_reg     <= b_next;
        idx_reg   <= idx_next;
        found_reg <= found_next;
        slot_reg  <= slot_next;
        fok_reg   <= fok_next;
        fslot_reg <= fslot_next;
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        cnt_reg   <= cnt_next;
        nb_reg    <= nb_next;
        dname_reg <= dname_next;
        mstat_reg <= mstat_next;
        mblk_reg  <= mblk_next;
    end

endmodule
